@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the rate limiter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWBRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("swbrl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWBRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swbrl assertion failed");

`endif

@@ hw/rtl/swbrl_pkg.sv @@
// Package of the sliding window byte rate limiter: entry type, codes, reset values.
// No dependencies; used by the log memory, the top level and the checker.
package swbrl_pkg;

	localparam int unsigned LOG_DEPTH_DEF = 64;

	localparam int unsigned IN_TDATA_W  = 64;  // 32 + 24 + 2 = 58, padded to bytes
	localparam int unsigned OUT_TDATA_W = 40;  // 1 + 32 = 33, padded to bytes
	localparam int unsigned PADDR_W     = 3;

	// Request kinds carried on tuser
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Send outcome codes
	localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;
	localparam logic [1:0] OUTCOME_FAILED  = 2'd1;
	localparam logic [1:0] OUTCOME_DROPPED = 2'd2;

	// Register index, taken from paddr[2]
	localparam logic REG_LIMIT  = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	localparam logic [31:0] LIMIT_RESET  = 32'd1250000;
	localparam logic [31:0] WINDOW_RESET = 32'd1000000;

	typedef struct packed {
		logic        counted;
		logic [23:0] size;
		logic [31:0] stamp;
	} log_entry_t;

endpackage

@@ hw/rtl/swbrl_log_ram.sv @@
// Packet log memory: one write port, one read port with registered read data.
// Depends on swbrl_pkg for the entry type.
module swbrl_log_ram #(
	parameter int unsigned DEPTH = swbrl_pkg::LOG_DEPTH_DEF,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  swbrl_pkg::log_entry_t  wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output swbrl_pkg::log_entry_t  rd_data
);
	import swbrl_pkg::*;

	log_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sliding_window_byte_rate_limiter_unit.sv @@
// Sliding window byte rate limiter: record requests keep tready high.
// A query request walks the filled log entries (at most LOG_DEPTH) and then raises its
// result, later while an earlier result waits; tready is low meanwhile, so the block
// takes no new request until the query is through, with each entry visited once by the
// single log read port and the one compare-and-add unit.
// Reset (arst_n, asynchronous, active low) empties the log and loads the default registers.
module sliding_window_byte_rate_limiter_unit #(
	parameter int unsigned LOG_DEPTH = swbrl_pkg::LOG_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] timestamp, [55:32] byte_count, [57:56] send_outcome, [63:58] zero
	input  logic [swbrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [0] req_type
	input  logic                                s_axis_tuser,
	// Result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] may_send, [32:1] window_bytes, [39:33] zero
	output logic [swbrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swbrl_pkg::PADDR_W-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import swbrl_pkg::*;

	localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]    state_q;
	logic [31:0]   limit_q;
	logic [31:0]   window_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic          m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Query operands and running sum
	logic [31:0]   q_time_q;
	logic [23:0]   q_bytes_q;
	logic [31:0]   win_start_q;
	logic [31:0]   sum_q;

	logic          in_acc;
	logic          cfg_wr;
	logic          rec_wr;
	logic          issue;
	logic          hit;
	logic          out_free;
	logic [32:0]   sum_add;
	logic [32:0]   total;
	log_entry_t    wr_entry;
	log_entry_t    rd_entry;

	// The block takes a new request only between queries.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign rec_wr        = in_acc && (s_axis_tuser == REQ_RECORD);

	assign wr_entry.stamp   = s_axis_tdata[31:0];
	assign wr_entry.size    = s_axis_tdata[55:32];
	assign wr_entry.counted = (s_axis_tdata[57:56] != OUTCOME_DROPPED);

	// Configuration: word index is paddr[2], byte lanes ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_WINDOW) ? window_q : limit_q;

	// Walk only the valid entries; unwritten slots are never read.
	assign issue = (state_q == ST_SCAN) && (scan_idx_q < fill_q);

	swbrl_log_ram #(
		.DEPTH (LOG_DEPTH),
		.AW    (AW)
	) u_log (
		.clk     (clk),
		.wr_en   (rec_wr),
		.wr_addr (slot_q),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_addr (scan_idx_q[AW-1:0]),
		.rd_data (rd_entry)
	);

	// Shared compare-and-add: one entry per cycle, sum saturates at all ones.
	assign hit     = rd_vld_s1 && rd_entry.counted && (rd_entry.stamp >= win_start_q);
	assign sum_add = {1'b0, sum_q} + {9'd0, rd_entry.size};

	// Final decision: exact 33-bit compare, no wrap.
	assign total    = {1'b0, sum_q} + {9'd0, q_bytes_q};
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			limit_q    <= LIMIT_RESET;
			window_q   <= WINDOW_RESET;
			slot_q     <= '0;
			fill_q     <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_WINDOW) begin
					window_q <= pwdata;
				end else begin
					limit_q <= pwdata;
				end
			end

			// Advance the ring write pointer and the fill count on a record.
			if (rec_wr) begin
				slot_q <= (slot_q == AW'(LOG_DEPTH - 1)) ? '0 : slot_q + 1'b1;
				if (fill_q != CW'(LOG_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			rd_vld_s1 <= issue;

			// Drop the result once the consumer takes it.
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == REQ_QUERY)) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					scan_idx_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hold the result until the output register is free.
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			q_time_q  <= s_axis_tdata[31:0];
			q_bytes_q <= s_axis_tdata[55:32];
		end
		if (state_q == ST_START) begin
			// Window start saturates at zero.
			win_start_q <= (q_time_q >= window_q) ? (q_time_q - window_q) : '0;
			sum_q       <= '0;
		end else if ((state_q == ST_SCAN) && hit) begin
			sum_q <= sum_add[32] ? '1 : sum_add[31:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			m_data_q <= {7'd0, sum_q, (total < {1'b0, limit_q})};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

@@ hw/rtl/swbrl_checker.sv @@
// Port-level checker of the rate limiter, bound to the top level.
// Depends on swbrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swbrl_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                s_axis_tuser,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [swbrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import swbrl_pkg::*;

	logic q_acc;
	logic r_acc;

	assign q_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_QUERY);
	assign r_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_RECORD);

	// A query occupies the block: no request is taken in the next cycle.
	`SWBRL_ASSERT_NEXT(a_query_busy, clk, arst_n, q_acc, !s_axis_tready)

	// After a record the block is ready for a request in the next cycle.
	`SWBRL_ASSERT_NEXT(a_record_one_cycle, clk, arst_n, r_acc, s_axis_tready)

	// A new result only appears at the end of a query, while requests were held off.
	`SWBRL_ASSERT_NOW(a_result_after_query, clk, arst_n, $rose(m_axis_tvalid),
		$past(!s_axis_tready))

	// A stalled result holds its value.
	`SWBRL_ASSERT_NEXT(a_result_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sliding_window_byte_rate_limiter_unit swbrl_checker u_swbrl_checker (.*);

@@ test/tb_sliding_window_byte_rate_limiter_unit.sv @@
`timescale 1ns / 100ps
// Testbench of sliding_window_byte_rate_limiter_unit: a directed table, then random record
// and query requests; each result is checked against a table value or a local prediction.
// Depends on swbrl_pkg and the rate limiter RTL only.
module tb_sliding_window_byte_rate_limiter_unit;
	import swbrl_pkg::*;

	// Outcome three has no name in the package; it counts like a failed send
	localparam logic [1:0] OUTCOME_OTHER = 2'd3;

	// Register addresses: index in paddr[2], byte aligned
	localparam logic [PADDR_W-1:0] ADDR_LIMIT  = {REG_LIMIT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};

	// Let the block settle this long before a register write
	localparam int unsigned HOLD_OFF = 8;
	// Wait at the end for longer than the longest query over a full log
	localparam int unsigned DRAIN_CYCLES = LOG_DEPTH_DEF + 16;
	localparam int unsigned N_PROBES = 22;

	typedef struct packed {
		logic        kind;
		logic [31:0] stamp;
		logic [23:0] bytes;
		logic [1:0]  outcome;
	} request_t;

	typedef struct packed {
		logic        may;
		logic [31:0] sum;
	} verdict_t;

	// One row of the directed table; typed rows carry their verdict, the rest are predicted
	typedef struct packed {
		logic     typed;
		verdict_t verdict;
		request_t req;
	} probe_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	sliding_window_byte_rate_limiter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// Local copy of the packet log and the two registers
	logic [31:0] hist_stamp   [LOG_DEPTH_DEF];
	logic [23:0] hist_size    [LOG_DEPTH_DEF];
	logic        hist_counted [LOG_DEPTH_DEF];
	int unsigned hist_slot;
	int unsigned hist_fill;
	logic [31:0] rate_limit;
	logic [31:0] window_len;

	// Verdicts of accepted queries, oldest first
	verdict_t pending_verdicts [$];

	int unsigned n_errors;
	int unsigned n_records;
	int unsigned n_queries;
	int unsigned n_results;
	int unsigned n_settings;

	// Runs of back-to-back traffic on each side
	bit src_steady;
	bit snk_steady;

	// Directed table, walked once after reset with the default registers.
	// Log contents are built up row by row; the typed sums follow from the rows above.
	probe_t probes [N_PROBES] = '{
		// Empty log: sum is zero, grant only below the limit
		{1'b1, 1'b1, 32'd0,        {REQ_QUERY,  32'd0,          24'd0,       OUTCOME_SUCCESS}},
		{1'b1, 1'b1, 32'd0,        {REQ_QUERY,  32'd0,          24'd1249999, OUTCOME_SUCCESS}},
		{1'b1, 1'b0, 32'd0,        {REQ_QUERY,  32'd0,          24'd1250000, OUTCOME_SUCCESS}},
		{1'b1, 1'b0, 32'd0,        {REQ_QUERY,  32'd0,          24'hFFFFFF,  OUTCOME_SUCCESS}},
		// One of each outcome; dropped does not count
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'd100,        24'd1000,    OUTCOME_SUCCESS}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'd200,        24'd2000,    OUTCOME_FAILED}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'd300,        24'd4000,    OUTCOME_DROPPED}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'd400,        24'd8000,    OUTCOME_OTHER}},
		// Window longer than the query time: start clamps to zero
		{1'b1, 1'b1, 32'd11000,    {REQ_QUERY,  32'd500,        24'd0,       OUTCOME_SUCCESS}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'd1000200,    24'd16000,   OUTCOME_SUCCESS}},
		// Window start exactly on an entry, then one tick past it
		{1'b1, 1'b1, 32'd26000,    {REQ_QUERY,  32'd1000200,    24'd0,       OUTCOME_SUCCESS}},
		{1'b1, 1'b1, 32'd24000,    {REQ_QUERY,  32'd1000201,    24'd0,       OUTCOME_SUCCESS}},
		// Query older than the log: newer entries still count
		{1'b1, 1'b1, 32'd27000,    {REQ_QUERY,  32'd100,        24'd0,       OUTCOME_SUCCESS}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'hFFFFFFFF,   24'hFFFFFF,  OUTCOME_SUCCESS}},
		{1'b1, 1'b0, 32'd16777215, {REQ_QUERY,  32'hFFFFFFFF,   24'd0,       OUTCOME_SUCCESS}},
		{1'b1, 1'b0, 32'd16804215, {REQ_QUERY,  32'd0,          24'd0,       OUTCOME_SUCCESS}},
		// Alternating bit patterns in some fields, then queries with predicted verdicts
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'hAAAAAAAA,   24'h555555,  OUTCOME_FAILED}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'h55555555,   24'hAAAAAA,  OUTCOME_SUCCESS}},
		{1'b0, 1'b0, 32'd0,        {REQ_RECORD, 32'h55555555,   24'd0,       OUTCOME_DROPPED}},
		{1'b0, 1'b0, 32'd0,        {REQ_QUERY,  32'h80000000,   24'd1,       OUTCOME_SUCCESS}},
		{1'b0, 1'b0, 32'd0,        {REQ_QUERY,  32'd1000300,    24'd1222999, OUTCOME_DROPPED}},
		{1'b0, 1'b0, 32'd0,        {REQ_QUERY,  32'h55555555,   24'h555555,  OUTCOME_OTHER}}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		n_errors++;
		$display("mismatch: %s: got 0x%0h, want 0x%0h at %0t ns", what, got, want, $time);
	endtask

	function automatic int unsigned pick_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	// Append one packet to the local log, overwriting the oldest entry when full
	function automatic void record_packet(input request_t r);
		hist_stamp[hist_slot]   = r.stamp;
		hist_size[hist_slot]    = r.bytes;
		hist_counted[hist_slot] = (r.outcome != OUTCOME_DROPPED);
		hist_slot = (hist_slot + 1) % LOG_DEPTH_DEF;
		if (hist_fill < LOG_DEPTH_DEF) begin
			hist_fill++;
		end
	endfunction

	// Sum the counted bytes inside the window and decide whether the send fits
	function automatic verdict_t judge_send(input request_t r);
		logic [31:0] start;
		logic [32:0] acc;
		logic [32:0] total;
		verdict_t v;
		start = (r.stamp >= window_len) ? r.stamp - window_len : 32'd0;
		acc = '0;
		for (int i = 0; i < hist_fill; i++) begin
			if (hist_counted[i] && hist_stamp[i] >= start) begin
				acc = acc + {9'd0, hist_size[i]};
				// Saturate at the top of 32 bits
				if (acc > 33'hFFFFFFFF) begin
					acc = 33'hFFFFFFFF;
				end
			end
		end
		total = {1'b0, acc[31:0]} + {9'd0, r.bytes};
		v.may = (total < {1'b0, rate_limit});
		v.sum = acc[31:0];
		return v;
	endfunction

	// Setup cycle, then access cycle until pready; then drop psel and idle before returning
	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
		input logic [31:0] data, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Read both registers back and compare with the local copy
	task automatic check_registers();
		logic [31:0] rd;
		apb_access(1'b0, ADDR_LIMIT, 32'd0, rd);
		if (rd !== rate_limit) begin
			report_mismatch("byte_rate_limit readback", rd, rate_limit);
		end
		apb_access(1'b0, ADDR_WINDOW, 32'd0, rd);
		if (rd !== window_len) begin
			report_mismatch("window_length readback", rd, window_len);
		end
	endtask

	task automatic set_registers(input logic [31:0] limit, input logic [31:0] window);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_LIMIT, limit, rd);
		apb_access(1'b1, ADDR_WINDOW, window, rd);
		rate_limit = limit;
		window_len = window;
		n_settings++;
		check_registers();
	endtask

	// Drop tvalid and hold the sender until every query has answered
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	// Offer one request; on acceptance update the log or queue the verdict.
	// tvalid is left high, so back-to-back requests keep it asserted.
	task automatic send_request(input request_t r, input bit typed, input verdict_t typed_v);
		int unsigned gap;
		logic [IN_TDATA_W-1:0] word;
		gap = pick_gap(src_steady);
		if ($urandom_range(0, 39) == 0) begin
			src_steady = !src_steady;
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[57:0] = {r.outcome, r.bytes, r.stamp};
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.kind;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		if (r.kind == REQ_RECORD) begin
			record_packet(r);
			n_records++;
		end else begin
			pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : judge_send(r));
			n_queries++;
		end
	endtask

	// One phase of random traffic under one register setting. Timestamps mostly climb
	// by up to step_max; a few jump anywhere to put entries out of order.
	task automatic run_phase(input logic [31:0] limit, input logic [31:0] window,
		input int unsigned step_max, input int unsigned size_max, input int unsigned query_max,
		input int unsigned count);
		request_t r;
		logic [31:0] now;
		int unsigned pick;
		wait_idle();
		set_registers(limit, window);
		now = $urandom();
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			r.kind = (pick < 45) ? REQ_QUERY : REQ_RECORD;
			now = now + $urandom_range(0, step_max);
			r.stamp = ($urandom_range(0, 24) == 0) ? $urandom() : now;
			if ($urandom_range(0, 19) == 0) begin
				r.bytes = 24'($urandom_range(0, 24'hFFFFFF));
			end else if (r.kind == REQ_QUERY) begin
				r.bytes = 24'($urandom_range(0, query_max));
			end else begin
				r.bytes = 24'($urandom_range(0, size_max));
			end
			r.outcome = 2'($urandom_range(0, 3));
			send_request(r, 1'b0, '0);
		end
	endtask

	// Result side: stall at random, then check each result against the oldest verdict
	initial begin
		int unsigned gap;
		verdict_t got;
		verdict_t want;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap(snk_steady);
			if ($urandom_range(0, 39) == 0) begin
				snk_steady = !snk_steady;
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.may = m_axis_tdata[0];
			got.sum = m_axis_tdata[32:1];
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with no query waiting", got.sum, 32'd0);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.may !== want.may) begin
					report_mismatch("may_send", {31'd0, got.may}, {31'd0, want.may});
				end
				if (got.sum !== want.sum) begin
					report_mismatch("window_bytes", got.sum, want.sum);
				end
				n_results++;
			end
		end
	end

	// Request side and run control
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_RECORD;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= ADDR_LIMIT;
		pwdata        <= '0;
		hist_slot  = 0;
		hist_fill  = 0;
		rate_limit = LIMIT_RESET;
		window_len = WINDOW_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then the directed table under them
		check_registers();
		for (int i = 0; i < N_PROBES; i++) begin
			send_request(probes[i].req, probes[i].typed, probes[i].verdict);
		end

		// Zero limit: never grant
		run_phase(32'd0, 32'd1000, 100, 4095, 4095, 120);
		// Both registers at the top: every entry in the window, nearly always grant
		run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 1 << 20, 24'hFFFFFF, 24'hFFFFFF, 150);
		// Zero window: only entries at or after the query time count
		run_phase(32'd30000, 32'd0, 3, 20000, 20000, 120);
		// Smallest non-zero limit and window
		run_phase(32'd1, 32'd1, 2, 3, 3, 120);
		// Balanced: sums hover around the limit
		run_phase(32'd20000, 32'd2000, 200, 4095, 16380, 300);
		// Random setting
		begin
			logic [31:0] win;
			win = $urandom_range(100, 100000);
			run_phase($urandom_range(1000, 200000), win, win / 8 + 1, 8191, 32767, 300);
		end
		// Back to the reset setting
		run_phase(LIMIT_RESET, WINDOW_RESET, 65536, 65535, 1 << 20, 140);

		// Hold until every query has answered, then let the block drain
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d records, %0d queries, %0d results checked", n_records,
			n_queries, n_results);
		$display("summary: %0d register settings, %0d mismatches", n_settings, n_errors);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
